>>> src/assert_macros.svh
// assertion macros included by the top-level rtl file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> src/psk_fd_pkg.sv
// types and constants of the path sum key descriptor table
// no dependencies
package psk_fd_pkg;

	localparam int SLOT_COUNT = 32;
	localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int KEY_W      = 32;
	localparam int SKEY_W     = 16;
	localparam int VAL_W      = 21;
	localparam int DESC_W     = 20;
	localparam int CHAR_W     = 8;
	localparam logic [KEY_W-1:0] CHAR_BIAS = 32'd48;
	localparam logic [VAL_W-1:0] VAL_NONE  = {VAL_W{1'b1}};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_TEST
	} state_t;

	typedef struct packed {
		logic acc;       // add character to key sum
		logic launch;    // latch operation, clear sum, index to zero
		logic rd;        // read slot at index
		logic adv;       // step index
		logic wr;        // write slot at index
		logic emit;      // register a result
		logic emit_ok;   // success bit of the result
		logic emit_rd;   // result value from the slot, else -1
	} ctrl_cmd_t;

	typedef struct packed {
		logic term;      // incoming character is zero
		logic retrieve;  // latched operation is retrieve
		logic match;     // slot key equals full sum
		logic val_none;  // slot value is -1
		logic free;      // slot key is zero
		logic last;      // index at last slot
	} ctrl_status_t;

endpackage

>>> src/psk_fd_ctrl.sv
// controller state machine of the descriptor table
// depends on psk_fd_pkg
module psk_fd_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  psk_fd_pkg::ctrl_status_t  st,
	output psk_fd_pkg::ctrl_cmd_t     cmd
);
	import psk_fd_pkg::*;

	state_t state_q, state_d;
	logic   finish;

	// scan ends on this slot
	always_comb begin
		if (st.retrieve) begin
			finish = st.match || st.last;
		end else begin
			finish = (st.match && !st.val_none) || st.free || st.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start && st.term) state_d = ST_READ;
			end
			ST_READ: state_d = ST_TEST;
			ST_TEST: begin
				state_d = finish ? ST_IDLE : ST_READ;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy       = 1'b0;
				cmd.acc    = start && !st.term;
				cmd.launch = start && st.term;
			end
			ST_READ: cmd.rd = 1'b1;
			ST_TEST: begin
				if (st.retrieve) begin
					if (st.match) begin
						cmd.emit    = 1'b1;
						cmd.emit_ok = !st.val_none;
						cmd.emit_rd = 1'b1;
					end else if (st.last) begin
						cmd.emit = 1'b1;
					end else begin
						cmd.adv = 1'b1;
					end
				end else begin
					if (st.match && !st.val_none) begin
						cmd.emit = 1'b1;
					end else if (st.free) begin
						cmd.wr      = 1'b1;
						cmd.emit    = 1'b1;
						cmd.emit_ok = 1'b1;
					end else if (st.last) begin
						cmd.emit = 1'b1;
					end else begin
						cmd.adv = 1'b1;
					end
				end
			end
			default: busy = 1'b0;
		endcase
	end

endmodule

>>> src/psk_fd_dpath.sv
// datapath of the descriptor table: key sum, slot memory, result registers
// depends on psk_fd_pkg
module psk_fd_dpath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               mode,
	input  logic [psk_fd_pkg::CHAR_W-1:0]      path_char,
	input  logic [psk_fd_pkg::DESC_W-1:0]      descriptor_in,
	input  psk_fd_pkg::ctrl_cmd_t              cmd,
	output psk_fd_pkg::ctrl_status_t           st,
	output logic                               done,
	output logic                               success,
	output logic signed [psk_fd_pkg::VAL_W-1:0] descriptor_out
);
	import psk_fd_pkg::*;

	logic [KEY_W-1:0]      acc_q;
	logic [KEY_W-1:0]      op_key_q;
	logic                  op_mode_q;
	logic [DESC_W-1:0]     op_desc_q;
	logic [IDX_W-1:0]      idx_q;
	logic [SLOT_COUNT-1:0] valid_q;

	logic [SKEY_W-1:0] key_mem [SLOT_COUNT];
	logic [VAL_W-1:0]  val_mem [SLOT_COUNT];
	logic [SKEY_W-1:0] rd_key_q;
	logic [VAL_W-1:0]  rd_val_q;
	logic              rd_valid_q;
	logic [SKEY_W-1:0] slot_key;
	logic [VAL_W-1:0]  slot_val;

	logic              done_q;
	logic              success_q;
	logic [VAL_W-1:0]  result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (cmd.launch) begin
			acc_q <= '0;
		end else if (cmd.acc) begin
			acc_q <= acc_q + KEY_W'(path_char) - CHAR_BIAS;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.launch) begin
			op_key_q  <= acc_q;
			op_mode_q <= mode;
			op_desc_q <= descriptor_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.launch) begin
			idx_q <= '0;
		end else if (cmd.adv) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	// written slots; an unwritten one reads as key zero, value -1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.wr) begin
			valid_q[idx_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			key_mem[idx_q] <= op_key_q[SKEY_W-1:0];
			val_mem[idx_q] <= VAL_W'(op_desc_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_key_q   <= key_mem[idx_q];
			rd_val_q   <= val_mem[idx_q];
			rd_valid_q <= valid_q[idx_q];
		end
	end

	assign slot_key = rd_valid_q ? rd_key_q : '0;
	assign slot_val = rd_valid_q ? rd_val_q : VAL_NONE;

	assign st.term     = (path_char == '0);
	assign st.retrieve = op_mode_q;
	assign st.match    = (KEY_W'(slot_key) == op_key_q);
	assign st.val_none = (slot_val == VAL_NONE);
	assign st.free     = (slot_key == '0);
	assign st.last     = (idx_q == IDX_W'(SLOT_COUNT - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			success_q <= cmd.emit_ok;
			result_q  <= cmd.emit_rd ? slot_val : VAL_NONE;
		end
	end

	assign done           = done_q;
	assign success        = success_q;
	assign descriptor_out = $signed(result_q);

endmodule

>>> src/path_sum_key_fd_table_unit.sv
// top level of the path sum key descriptor table
// depends on psk_fd_pkg, psk_fd_ctrl, psk_fd_dpath, assert_macros.svh
//
// usage:
//   a request is taken at a rising edge with start high and busy low; it
//   carries mode, path_char and descriptor_in
//   a non-zero path_char adds (path_char - 48) to a 32-bit wrapping key sum
//   and gives no result; busy stays low
//   a zero path_char ends the name: the sum is latched and cleared, and the
//   slots are scanned in order, each with a memory read, then a test
//   busy is high while k slots are scanned (k from 1 to SLOT_COUNT)
//   the result (success, descriptor_out) shows for one cycle with done high,
//   in the cycle after the last test, the same cycle busy drops
//   the receiver cannot stall: done is a strobe, nothing is held
//   the slot scan through the single-port slot memory sets the latency;
//   characters run at one per cycle while busy is low
//   reset clears the key sum and all slot valid bits at once, so every slot
//   reads as free (key zero, value -1); no clearing pass is needed
//   retrieve returns the first slot whose key equals the full 32-bit sum;
//   insert stores the low 16 bits of the sum, so a sum above 16 bits is
//   never found again
`include "assert_macros.svh"

module path_sum_key_fd_table_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                mode,
	input  logic [psk_fd_pkg::CHAR_W-1:0]       path_char,
	input  logic [psk_fd_pkg::DESC_W-1:0]       descriptor_in,
	output logic                                done,
	output logic                                success,
	output logic signed [psk_fd_pkg::VAL_W-1:0] descriptor_out
);
	import psk_fd_pkg::*;

	ctrl_cmd_t    cmd;
	ctrl_status_t st;

	// sequencer: idle, slot read, slot test
	psk_fd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.st     (st),
		.cmd    (cmd)
	);

	// key sum, slot memory with valid bits, result registers
	psk_fd_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.mode           (mode),
		.path_char      (path_char),
		.descriptor_in  (descriptor_in),
		.cmd            (cmd),
		.st             (st),
		.done           (done),
		.success        (success),
		.descriptor_out (descriptor_out)
	);

	// a result only follows a scan
	`ASSERT_IMPLIES(a_done_after_busy, clk, arst_n, done, $past(busy))
	// a real descriptor comes out only on a retrieve hit
	`ASSERT_IMPLIES(a_value_means_hit, clk, arst_n, done && (descriptor_out != VAL_NONE), success)
	// slots are written only during a scan
	`ASSERT_IMPLIES(a_write_in_scan, clk, arst_n, cmd.wr, busy && cmd.emit)
	// a terminator starts a scan
	`ASSERT_NEXT(a_launch_busy, clk, arst_n, cmd.launch, busy)

endmodule
